FILE: sv/rscl_pkg.sv
// Shared types and constants of the ranging sensor command link.
package rscl_pkg;

    localparam int FRAME_BYTES = 4;
    localparam int CMD_BYTES   = FRAME_BYTES - 1;

    // Request opcodes
    localparam logic [2:0] OP_DIST     = 3'd0;
    localparam logic [2:0] OP_TEMP     = 3'd1;
    localparam logic [2:0] OP_EEREAD   = 3'd2;
    localparam logic [2:0] OP_EEWRITE  = 3'd3;
    localparam logic [2:0] OP_RXBYTE   = 3'd4;
    localparam logic [2:0] OP_TIMEOUT  = 3'd5;

    // Completion status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOTSUP = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;
    localparam logic [1:0] ST_FAILED = 2'd3;

    // Result kinds
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_WIRED_ANALOG = 1'b0;
    localparam logic CFG_MAX_ATTEMPTS = 1'b1;

    // Sensor command bytes
    localparam logic [7:0] CMD_DIST    = 8'h22;
    localparam logic [7:0] CMD_TEMP    = 8'h11;
    localparam logic [7:0] CMD_EEREAD  = 8'h33;
    localparam logic [7:0] CMD_EEWRITE = 8'h44;

    localparam logic [7:0] EE_ADDR_MAX   = 8'h04;
    localparam int         ANGLE_STEP    = 6;
    localparam int         ANGLE_ARG_MAX = 46;
    localparam int         ANGLE_SHIFT   = 12;
    localparam int         ANGLE_RECIP   = ((1 << ANGLE_SHIFT) + ANGLE_STEP - 1) / ANGLE_STEP;

    localparam logic [7:0] TEMP_MAG_MASK  = 8'h0f;
    localparam logic [7:0] TEMP_SIGN_MASK = 8'hf0;

    localparam logic [3:0] MAX_ATTEMPTS_RESET = 4'd10;

    typedef logic [7:0] t_byte;
    typedef t_byte [CMD_BYTES-1:0] t_frame;

    typedef struct packed {
        logic       wired_analog;
        logic [3:0] max_attempts;
    } t_cfg;

    // What one request leaves for the output side: a whole command frame or a completion.
    typedef struct packed {
        logic        is_frame;
        t_frame      bytes;
        logic [1:0]  status;
        logic [15:0] reading;
        logic        reading_negative;
    } t_bundle;

endpackage

FILE: sv/rscl_if.sv
// Handshake interfaces of the ranging sensor command link.
interface rscl_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [8:0] angle_degrees;
    logic [7:0] eeprom_address;
    logic [7:0] eeprom_data;
    logic [7:0] received_byte;

    modport source(output valid, output opcode, output angle_degrees, output eeprom_address,
                   output eeprom_data, output received_byte, input ready);
    modport sink(input valid, input opcode, input angle_degrees, input eeprom_address,
                 input eeprom_data, input received_byte, output ready);
endinterface

interface rscl_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  transmit_byte;
    logic        frame_last;
    logic [1:0]  status;
    logic [15:0] reading;
    logic        reading_negative;

    modport source(output valid, output kind, output transmit_byte, output frame_last,
                   output status, output reading, output reading_negative, input ready);
    modport sink(input valid, input kind, input transmit_byte, input frame_last,
                 input status, input reading, input reading_negative, output ready);
endinterface

interface rscl_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [3:0] data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

FILE: sv/rscl_engine.sv
// Request decode, link state and retry control of the command link.
module rscl_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [2:0]       i_opcode,
    input  logic [8:0]       i_angle_degrees,
    input  logic [7:0]       i_eeprom_address,
    input  logic [7:0]       i_eeprom_data,
    input  logic [7:0]       i_received_byte,
    input  rscl_pkg::t_cfg   i_cfg,
    output logic             o_push,
    output rscl_pkg::t_bundle o_bundle
);
    import rscl_pkg::*;

    localparam int PROD_W = 9 + ANGLE_SHIFT + 1;

    logic        r_busy,     n_busy;
    logic [1:0]  r_pending,  n_pending;
    t_frame      r_cmd,      n_cmd;
    t_frame      r_resp,     n_resp;
    logic [1:0]  r_count,    n_count;
    logic [3:0]  r_attempts, n_attempts;

    logic [PROD_W-1:0] angle_prod;
    t_byte             angle_arg;
    t_frame            new_cmd;
    logic              range_bad;
    t_byte             resp_sum;
    logic              retry;
    t_byte             h_byte;
    t_byte             l_byte;

    // angle / 6 by reciprocal multiply, exact for any 9-bit angle
    assign angle_prod = PROD_W'(i_angle_degrees) * PROD_W'(ANGLE_RECIP);
    assign angle_arg  = 8'(angle_prod[PROD_W-1:ANGLE_SHIFT]);
    assign resp_sum   = r_resp[0] + r_resp[1] + r_resp[2];
    assign h_byte     = r_resp[1];
    assign l_byte     = r_resp[2];

    always_comb begin
        new_cmd   = '0;
        range_bad = 1'b0;
        case (i_opcode)
            OP_DIST: begin
                new_cmd   = {8'h00, angle_arg, CMD_DIST};
                range_bad = (angle_arg > 8'(ANGLE_ARG_MAX));
            end
            OP_TEMP: begin
                new_cmd = {8'h00, 8'h00, CMD_TEMP};
            end
            OP_EEREAD: begin
                new_cmd   = {8'h00, i_eeprom_address, CMD_EEREAD};
                range_bad = (i_eeprom_address > EE_ADDR_MAX);
            end
            default: begin
                new_cmd   = {i_eeprom_data, i_eeprom_address, CMD_EEWRITE};
                range_bad = (i_eeprom_address > EE_ADDR_MAX);
            end
        endcase
    end

    always_comb begin
        n_busy     = r_busy;
        n_pending  = r_pending;
        n_cmd      = r_cmd;
        n_resp     = r_resp;
        n_count    = r_count;
        n_attempts = r_attempts;
        retry      = 1'b0;
        o_push     = 1'b0;
        o_bundle   = '{is_frame: 1'b0, bytes: r_cmd, status: ST_OK,
                       reading: 16'h0000, reading_negative: 1'b0};
        if (i_accept) begin
            case (i_opcode)
                OP_DIST, OP_TEMP, OP_EEREAD, OP_EEWRITE: begin
                    if (!r_busy) begin
                        o_push = 1'b1;
                        if (i_cfg.wired_analog) begin
                            o_bundle.status = ST_NOTSUP;
                        end else if (range_bad) begin
                            o_bundle.status = ST_RANGE;
                        end else begin
                            n_cmd             = new_cmd;
                            n_pending         = i_opcode[1:0];
                            n_busy            = 1'b1;
                            n_attempts        = 4'd1;
                            n_count           = 2'd0;
                            o_bundle.is_frame = 1'b1;
                            o_bundle.bytes    = new_cmd;
                        end
                    end
                end
                OP_RXBYTE: begin
                    if (r_busy) begin
                        if (r_count != 2'(CMD_BYTES)) begin
                            n_resp[r_count] = i_received_byte;
                            n_count         = r_count + 2'd1;
                        end else if (resp_sum == i_received_byte) begin
                            n_busy  = 1'b0;
                            n_count = 2'd0;
                            o_push  = 1'b1;
                            case (r_pending)
                                OP_DIST[1:0]: o_bundle.reading = {h_byte, l_byte};
                                OP_TEMP[1:0]: begin
                                    o_bundle.reading          = {4'h0, h_byte[3:0], l_byte}
                                                                & {4'h0, TEMP_MAG_MASK[3:0], 8'hff};
                                    o_bundle.reading_negative = |(h_byte & TEMP_SIGN_MASK);
                                end
                                OP_EEREAD[1:0]: o_bundle.reading = {8'h00, l_byte};
                                default:        o_bundle.reading = 16'h0000;
                            endcase
                        end else begin
                            retry = 1'b1;
                        end
                    end
                end
                OP_TIMEOUT: begin
                    retry = r_busy;
                end
                default: begin
                end
            endcase

            // resend the stored frame, or give up once the budget is spent
            if (retry) begin
                o_push  = 1'b1;
                n_count = 2'd0;
                if (r_attempts < i_cfg.max_attempts) begin
                    n_attempts        = r_attempts + 4'd1;
                    o_bundle.is_frame = 1'b1;
                end else begin
                    n_busy          = 1'b0;
                    o_bundle.status = ST_FAILED;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_pending  <= 2'd0;
            r_count    <= 2'd0;
            r_attempts <= 4'd0;
        end else begin
            r_busy     <= n_busy;
            r_pending  <= n_pending;
            r_count    <= n_count;
            r_attempts <= n_attempts;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_resp <= n_resp;
    end

endmodule

FILE: sv/rscl_serializer.sv
// Holding slot and byte sequencer that turns request outcomes into result beats.
module rscl_serializer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rscl_pkg::t_bundle i_bundle,
    output logic              o_slot_free,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_kind,
    output logic [7:0]        o_transmit_byte,
    output logic              o_frame_last,
    output logic [1:0]        o_status,
    output logic [15:0]       o_reading,
    output logic              o_reading_negative
);
    import rscl_pkg::*;

    localparam logic [1:0] LAST_BEAT = 2'(FRAME_BYTES - 1);

    logic      r_slot_v;
    t_bundle   r_slot;
    logic      r_cur_v;
    t_bundle   r_cur;
    logic [1:0] r_idx;

    logic  last_beat;
    logic  cur_done;
    logic  slot_move;
    t_byte frame_sum;

    assign last_beat = !r_cur.is_frame || (r_idx == LAST_BEAT);
    assign cur_done  = r_cur_v && i_ready && last_beat;
    assign slot_move = r_slot_v && (!r_cur_v || cur_done);
    assign frame_sum = r_cur.bytes[0] + r_cur.bytes[1] + r_cur.bytes[2];

    assign o_slot_free = !r_slot_v;
    assign o_valid     = r_cur_v;

    always_comb begin
        o_kind             = r_cur.is_frame ? KIND_TX : KIND_DONE;
        o_frame_last       = r_cur.is_frame && (r_idx == LAST_BEAT);
        o_status           = r_cur.is_frame ? ST_OK : r_cur.status;
        o_reading          = r_cur.is_frame ? 16'h0000 : r_cur.reading;
        o_reading_negative = !r_cur.is_frame && r_cur.reading_negative;
        o_transmit_byte    = 8'h00;
        if (r_cur.is_frame) begin
            if (r_idx == LAST_BEAT) begin
                o_transmit_byte = frame_sum;
            end else begin
                o_transmit_byte = r_cur.bytes[r_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_v <= 1'b0;
            r_cur_v  <= 1'b0;
            r_idx    <= 2'd0;
        end else begin
            if (i_push) begin
                r_slot_v <= 1'b1;
            end else if (slot_move) begin
                r_slot_v <= 1'b0;
            end
            if (slot_move) begin
                r_cur_v <= 1'b1;
                r_idx   <= 2'd0;
            end else if (cur_done) begin
                r_cur_v <= 1'b0;
            end else if (r_cur_v && i_ready) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot <= i_bundle;
        end
        if (slot_move) begin
            r_cur <= r_slot;
        end
    end

endmodule

FILE: sv/ranging_sensor_command_link_core.sv
// Top level of the ranging sensor command link, host side.
//
//  channel | dir | carries
//  --------+-----+------------------------------------------------------------
//  i_req   | in  | request: opcode, angle, EEPROM address/data, received byte
//  o_res   | out | result: transmit byte (frame beat) or completion with reading
//  i_cfg   | in  | register write: index 0 wired_analog, index 1 max_attempts
//
// A request is decoded and the link state updated in the cycle it is taken;
// its outcome lands in a one-entry holding slot, then in the output register
// once the current result has left. A frame send is four beats, a completion
// one; one beat leaves per cycle while o_res.ready is high, and the slot can
// take the next outcome while a frame is still being sent. i_req.ready is high
// whenever the holding slot is empty and reset is released; an output stall
// holds the current beat and, once the slot fills, holds off new requests.
// Reset is synchronous, active low, and returns the link to idle with
// max_attempts at ten and analog wiring off; i_cfg is ready outside reset.
module ranging_sensor_command_link_core (
    input logic      i_clk,
    input logic      i_rst_n,
    rscl_req_if.sink   i_req,
    rscl_res_if.source o_res,
    rscl_cfg_if.sink   i_cfg
);
    import rscl_pkg::*;

    t_cfg    r_cfg;
    logic    req_accept;
    logic    push;
    t_bundle bundle;
    logic    slot_free;

    // hold off both input channels while reset is applied
    assign i_cfg.ready = i_rst_n;
    assign i_req.ready = slot_free && i_rst_n;
    assign req_accept  = i_req.valid && i_req.ready;

    // configuration registers; write them only while the link is idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wired_analog <= 1'b0;
            r_cfg.max_attempts <= MAX_ATTEMPTS_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_WIRED_ANALOG: r_cfg.wired_analog <= i_cfg.data[0];
                CFG_MAX_ATTEMPTS: r_cfg.max_attempts <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // decode, range check, response collection and retry budget
    rscl_engine u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (req_accept),
        .i_opcode         (i_req.opcode),
        .i_angle_degrees  (i_req.angle_degrees),
        .i_eeprom_address (i_req.eeprom_address),
        .i_eeprom_data    (i_req.eeprom_data),
        .i_received_byte  (i_req.received_byte),
        .i_cfg            (r_cfg),
        .o_push           (push),
        .o_bundle         (bundle)
    );

    // hold the outcome, then advance through the frame bytes one per cycle while o_res.ready is high
    rscl_serializer u_serializer (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push),
        .i_bundle           (bundle),
        .o_slot_free        (slot_free),
        .o_valid            (o_res.valid),
        .i_ready            (o_res.ready),
        .o_kind             (o_res.kind),
        .o_transmit_byte    (o_res.transmit_byte),
        .o_frame_last       (o_res.frame_last),
        .o_status           (o_res.status),
        .o_reading          (o_res.reading),
        .o_reading_negative (o_res.reading_negative)
    );

endmodule

FILE: sv/rscl_checker.sv
// Port-level checks of the command link output stream, bound to the top level.
module rscl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_kind,
    input logic [7:0]  i_transmit_byte,
    input logic        i_frame_last,
    input logic [1:0]  i_status,
    input logic [15:0] i_reading,
    input logic        i_reading_negative
);
    import rscl_pkg::*;

    logic [1:0] r_beat;

    // count accepted frame bytes to know where in a frame the stream stands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= 2'd0;
        end else if (i_valid && i_ready && (i_kind == KIND_TX)) begin
            r_beat <= i_frame_last ? 2'd0 : r_beat + 2'd1;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_transmit_byte)
            && $stable(i_frame_last) && $stable(i_status) && $stable(i_reading))
        else $error("result changed while stalled");

    a_last_on_fourth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == KIND_TX) |-> i_frame_last == (r_beat == 2'(FRAME_BYTES - 1)))
        else $error("frame_last not on the checksum byte");

    a_done_between_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == KIND_DONE) |-> (r_beat == 2'd0) && !i_frame_last)
        else $error("completion inside a transmitted frame");

    a_error_no_reading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status != ST_OK) |->
            (i_kind == KIND_DONE) && (i_reading == 16'h0000) && !i_reading_negative)
        else $error("failed completion carries a reading");

endmodule

bind ranging_sensor_command_link_core rscl_checker u_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (o_res.valid),
    .i_ready            (o_res.ready),
    .i_kind             (o_res.kind),
    .i_transmit_byte    (o_res.transmit_byte),
    .i_frame_last       (o_res.frame_last),
    .i_status           (o_res.status),
    .i_reading          (o_res.reading),
    .i_reading_negative (o_res.reading_negative)
);
